/* rtl/fqks_pkg.sv */
// Shared types, constants and helpers for the record queue with kind partition.
package fqks_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Prize total: output width and internal accumulator width
  localparam int TOT_W = 20;
  localparam int SUM_W = (16 + CNT_W > TOT_W + 1) ? 16 + CNT_W : TOT_W + 1;
  localparam logic signed [SUM_W-1:0] TOT_MAX = SUM_W'((64'sd1 <<< (TOT_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] TOT_MIN = -SUM_W'(64'sd1 <<< (TOT_W - 1));

  typedef enum logic [2:0] {
    ACT_ENQ  = 3'd0,
    ACT_DEQ  = 3'd1,
    ACT_CLR  = 3'd2,
    ACT_PEEK = 3'd3,
    ACT_SUM  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One stored record
  typedef struct packed {
    logic        [31:0] name_tag;
    logic signed [15:0] prize;
    logic        [7:0]  kind;
    logic        [15:0] duration;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Request from the sequencer to the two record banks
  typedef struct packed {
    logic             we;
    logic             wbank;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic             rbank;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Circular slot: base plus offset, wrapped at the queue depth
  function automatic logic [IDX_W-1:0] slot_at(logic [IDX_W-1:0] base,
                                               logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

/* rtl/fqks_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fqks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fqks_ctrl.sv */
// Sequencer: queue pointers, shared compare/add unit for the partition scan, result register.
module fqks_ctrl import fqks_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              action,
  input  rec_t                    in_rec,
  input  logic [7:0]              query_kind,
  output mem_req_t                req,
  input  rec_t                    rdata,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output rec_t                    out_rec,
  output logic signed [TOT_W-1:0] prize_total
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SCAN, S_FINISH} state_t;

  state_t                  state;
  logic [IDX_W-1:0]        head;
  logic [CNT_W-1:0]        count;
  logic                    bank;
  logic                    is_deq;
  logic [7:0]              query;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        fill;
  logic                    pass;
  logic                    issue;
  logic                    p_vld;
  logic                    p_pass;
  logic signed [SUM_W-1:0] total;

  logic                    out_free;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    match;
  logic                    keep;
  logic                    last_idx;
  logic signed [TOT_W-1:0] sat_total;

  // Handshake and queue flags
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  // Shared compare on the beat returning from the current bank
  assign match    = (rdata.kind == query);
  assign keep     = p_vld && (match == !p_pass);
  assign last_idx = (idx == count - CNT_W'(1));

  // Clamp the total to the output range
  always_comb begin
    if (total > TOT_MAX) begin
      sat_total = TOT_MAX[TOT_W-1:0];
    end else if (total < TOT_MIN) begin
      sat_total = TOT_MIN[TOT_W-1:0];
    end else begin
      sat_total = total[TOT_W-1:0];
    end
  end

  // Bank requests: enqueue writes the current bank, the scan fills the other one
  always_comb begin
    req.we    = 1'b0;
    req.wbank = bank;
    req.waddr = slot_at(head, count[IDX_W-1:0]);
    req.wdata = in_rec;
    req.rbank = bank;
    req.raddr = (state == S_SCAN) ? slot_at(head, idx[IDX_W-1:0]) : head;
    if (state == S_IDLE && accept && action == ACT_ENQ && !full) begin
      req.we = 1'b1;
    end
    if (state == S_SCAN && keep) begin
      req.we    = 1'b1;
      req.wbank = !bank;
      req.waddr = slot_at(head, fill[IDX_W-1:0]);
      req.wdata = rdata;
    end
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      bank      <= 1'b0;
      out_valid <= 1'b0;
      issue     <= 1'b0;
      p_vld     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status      <= ST_OK;
            out_rec     <= '0;
            prize_total <= '0;
            unique case (action_t'(action)) inside
              ACT_ENQ: begin
                out_valid <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              ACT_DEQ, ACT_PEEK: begin
                if (empty) begin
                  out_valid <= 1'b1;
                  status    <= ST_EMPTY;
                end else begin
                  is_deq <= (action == ACT_DEQ);
                  state  <= S_READ;
                end
              end
              ACT_CLR: begin
                out_valid <= 1'b1;
                head      <= '0;
                count     <= '0;
              end
              ACT_SUM: begin
                if (empty) begin
                  out_valid <= 1'b1;
                end else begin
                  query <= query_kind;
                  idx   <= '0;
                  fill  <= '0;
                  pass  <= 1'b0;
                  issue <= 1'b1;
                  total <= '0;
                  state <= S_SCAN;
                end
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          // front record is on the read port
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= ST_OK;
            out_rec   <= rdata;
            if (is_deq) begin
              head  <= slot_at(head, IDX_W'(1));
              count <= count - CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // two passes: matching records first, then the rest
          p_vld  <= issue;
          p_pass <= pass;
          if (issue) begin
            if (last_idx) begin
              if (pass) begin
                issue <= 1'b0;
              end else begin
                pass <= 1'b1;
                idx  <= '0;
              end
            end else begin
              idx <= idx + CNT_W'(1);
            end
          end
          if (keep) begin
            fill <= fill + CNT_W'(1);
            if (!p_pass) begin
              total <= total + SUM_W'($signed(rdata.prize));
            end
          end
          if (!issue && !p_vld) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= ST_OK;
            out_rec     <= '0;
            prize_total <= sat_total;
            bank        <= !bank;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/fifo_queue_with_kind_partition_sum.sv */
// Record queue with kind partition and prize sum: two record banks and the sequencer.
// Enqueue, clear, unknown action and empty errors give their result straight from the idle state;
// dequeue and peek go through one registered bank read of the front slot.
// Prize sum (result straight from idle on an empty queue): two scan passes over the single
// bank read port copy the partition into the other bank, then the banks swap.
// One item at a time: the next beat is taken once the sequencer is idle and the result slot free.
// Synchronous reset empties the queue (head and count zero); bank contents are left as they are.
module fifo_queue_with_kind_partition_sum import fqks_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              action,
  input  logic [31:0]             name_tag,
  input  logic signed [15:0]      prize,
  input  logic [7:0]              kind,
  input  logic [15:0]             duration,
  input  logic [7:0]              query_kind,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [31:0]             out_name_tag,
  output logic signed [15:0]      out_prize,
  output logic [7:0]              out_kind,
  output logic [15:0]             out_duration,
  output logic signed [TOT_W-1:0] prize_total
);

  mem_req_t         req;
  rec_t             in_rec;
  rec_t             out_rec;
  rec_t             rdata;
  logic [REC_W-1:0] rd0;
  logic [REC_W-1:0] rd1;

  // Pack the input record
  assign in_rec.name_tag = name_tag;
  assign in_rec.prize    = prize;
  assign in_rec.kind     = kind;
  assign in_rec.duration = duration;

  // Record banks: one holds the queue, the other takes the partitioned copy
  fqks_ram #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (req.we && !req.wbank),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.raddr),
    .rdata (rd0)
  );

  fqks_ram #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (req.we && req.wbank),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.raddr),
    .rdata (rd1)
  );

  // Read data from the current bank
  assign rdata = req.rbank ? rec_t'(rd1) : rec_t'(rd0);

  fqks_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .in_rec      (in_rec),
    .query_kind  (query_kind),
    .req         (req),
    .rdata       (rdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_rec     (out_rec),
    .prize_total (prize_total)
  );

  // Unpack the result record
  assign out_name_tag = out_rec.name_tag;
  assign out_prize    = out_rec.prize;
  assign out_kind     = out_rec.kind;
  assign out_duration = out_rec.duration;

endmodule
